@@ hw/rtl/lidar_point_camera_projection_unit_defines.svh @@
// Assertion macros shared by the projection unit.
`ifndef LIDAR_POINT_CAMERA_PROJECTION_UNIT_DEFINES_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define LPCP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("projection unit assertion failed");
// Checked on every rising edge, reset included.
`define LPCP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("projection unit assertion failed");
`else
`define LPCP_ASSERT(lbl, clk, rst, prop)
`define LPCP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/lpcp_pkg.sv @@
`default_nettype none
package lpcp_pkg;
  localparam int PT_W   = 18;
  localparam int AX_W   = PT_W + 1;
  localparam int COEF_W = 32;
  localparam int PROD_W = COEF_W + AX_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int REG_W  = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_R0_C01   = 3'd0;
  localparam logic [IDX_W-1:0] REG_R0_C23   = 3'd1;
  localparam logic [IDX_W-1:0] REG_R1_C01   = 3'd2;
  localparam logic [IDX_W-1:0] REG_R1_C23   = 3'd3;
  localparam logic [IDX_W-1:0] REG_R2_C01   = 3'd4;
  localparam logic [IDX_W-1:0] REG_R2_C23   = 3'd5;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd6;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd7;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // Projection matrix, [row][coefficient].
  typedef logic [2:0][3:0][COEF_W-1:0] mat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] s0;
    logic signed [SUM_W-1:0] s1;
    logic signed [SUM_W-1:0] s2;
  } sums_t;
endpackage
`default_nettype wire

@@ hw/rtl/lidar_point_camera_projection_unit.sv @@
// Pipeline: the multiply-accumulate, log2(MAX_IMAGE_DIM) quotient stages and the output register.
// Throughput: one point per cycle while the output is accepted; every stage has its own valid bit and bubbles close up.
// Synchronous active-high reset empties the pipeline, clears the matrix to zero and
// sets the image size to 640 by 480.
`default_nettype none
`include "lidar_point_camera_projection_unit_defines.svh"
module lidar_point_camera_projection_unit import lpcp_pkg::*; #(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration writes.
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [REG_W-1:0]   cfg_data,
  // Input points.
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [55:0]        s_tdata,   // point_x[17:0], point_y[35:18], point_z[53:36]
  // Projected pixels.
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [23:0]             m_tdata,   // pixel_col[11:0], pixel_row[23:12]
  output logic [0:0]              m_tuser    // in_view[0]
);
  // Quotient bits: every pixel that can be in view lies below MAX_IMAGE_DIM.
  localparam int QB   = $clog2(MAX_IMAGE_DIM);
  localparam int CW   = (QB > DIM_W) ? QB : DIM_W;
  localparam int BNDW = CW + 1;

  logic [REG_W-1:0] coef_reg [6];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  mat_t             mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) coef_reg[i] <= '0;
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_R0_C01: coef_reg[0] <= cfg_data;
        REG_R0_C23: coef_reg[1] <= cfg_data;
        REG_R1_C01: coef_reg[2] <= cfg_data;
        REG_R1_C23: coef_reg[3] <= cfg_data;
        REG_R2_C01: coef_reg[4] <= cfg_data;
        REG_R2_C23: coef_reg[5] <= cfg_data;
        REG_WIDTH:  width_reg   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_reg  <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Each row's four coefficients sit in two registers, low word first.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat[r][0] = coef_reg[2*r][31:0];
      mat[r][1] = coef_reg[2*r][63:32];
      mat[r][2] = coef_reg[2*r+1][31:0];
      mat[r][3] = coef_reg[2*r+1][63:32];
    end
  end

  // The three row sums, exact, from the four-stage multiply-accumulate.
  logic  mac_valid;
  logic  mac_ready;
  sums_t sums;

  lpcp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .mat       (mat),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .px        (s_tdata[17:0]),
    .py        (s_tdata[35:18]),
    .pz        (s_tdata[53:36]),
    .out_valid (mac_valid),
    .out_ready (mac_ready),
    .sums      (sums)
  );

  // Both quotients share the depth as divisor. A point whose quotient would not
  // fit, whose depth is not positive or whose column or row is negative leaves
  // with live low.
  logic          div_valid;
  logic          div_ready;
  logic [QB-1:0] q0;
  logic [QB-1:0] q1;
  logic          live;

  lpcp_div #(.QB(QB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mac_valid),
    .in_ready  (mac_ready),
    .sums      (sums),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .q0        (q0),
    .q1        (q1),
    .live      (live)
  );

  // Image bounds saturate at MAX_IMAGE_DIM.
  logic [BNDW-1:0] bound_w;
  logic [BNDW-1:0] bound_h;
  logic            vis;

  always_comb begin
    bound_w = (BNDW'(width_reg) > BNDW'(MAX_IMAGE_DIM)) ? BNDW'(MAX_IMAGE_DIM)
                                                        : BNDW'(width_reg);
    bound_h = (BNDW'(height_reg) > BNDW'(MAX_IMAGE_DIM)) ? BNDW'(MAX_IMAGE_DIM)
                                                         : BNDW'(height_reg);
    vis     = live && (BNDW'(q0) < bound_w) && (BNDW'(q1) < bound_h);
  end

  // Output register: it takes a new beat whenever the current one is gone.
  logic [PIX_W-1:0] col;
  logic [PIX_W-1:0] row;
  logic             in_view;
  logic [CW-1:0]    q0_ext;
  logic [CW-1:0]    q1_ext;

  assign div_ready = !m_tvalid || m_tready;
  assign q0_ext    = CW'(q0);
  assign q1_ext    = CW'(q1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (div_ready) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) begin
      col     <= vis ? q0_ext[PIX_W-1:0] : '0;
      row     <= vis ? q1_ext[PIX_W-1:0] : '0;
      in_view <= vis;
    end
  end

  assign m_tdata = {row, col};
  assign m_tuser = in_view;

  // A point that is not in view carries zero pixel fields.
  `LPCP_ASSERT(a_hidden_zero, clk, rst, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
  // A visible column lies inside the saturated width.
  `LPCP_ASSERT(a_col_bound, clk, rst, (m_tvalid && m_tuser[0]) |-> (BNDW'(col) < bound_w))
  // With the output register empty the whole pipeline can move, so input is taken.
  `LPCP_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready)
  // The cycle after reset nothing is presented.
  `LPCP_ASSERT(a_reset_empty, clk, rst, $past(rst) |-> !m_tvalid)
endmodule
`default_nettype wire

@@ hw/rtl/lpcp_mac.sv @@
`default_nettype none
// Matrix-vector product over four stages: reorder, multiply, pair add, final add.
module lpcp_mac import lpcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mat_t              mat,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PT_W-1:0]   px,
  input  wire logic [PT_W-1:0]   py,
  input  wire logic [PT_W-1:0]   pz,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sums_t                  sums
);
  logic [3:0] v;
  logic [3:0] adv;

  logic signed [AX_W-1:0]     ax [3];
  logic signed [PROD_W-1:0]   p  [3][3];
  logic signed [COEF_W-1:0]   c3 [3];
  logic signed [PROD_W:0]     h  [3];
  logic signed [PROD_W:0]     g  [3];
  logic signed [SUM_W-1:0]    s  [3];

  always_comb begin
    adv[3] = !v[3] || out_ready;
    for (int i = 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[3];
  assign sums      = '{s0: s[0], s1: s[1], s2: s[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < 4; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // Camera axes are (-y, -z, x); the homogeneous one is the fourth coefficient.
  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      ax[0] <= -$signed({py[PT_W-1], py});
      ax[1] <= -$signed({pz[PT_W-1], pz});
      ax[2] <= $signed({px[PT_W-1], px});
    end
    if (adv[1] && v[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          p[r][k] <= $signed(mat[r][k]) * ax[k];
        end
        c3[r] <= $signed(mat[r][3]);
      end
    end
    if (adv[2] && v[1]) begin
      for (int r = 0; r < 3; r++) begin
        h[r] <= (PROD_W+1)'(p[r][0]) + (PROD_W+1)'(p[r][1]);
        g[r] <= (PROD_W+1)'(p[r][2]) + (PROD_W+1)'(c3[r]);
      end
    end
    if (adv[3] && v[2]) begin
      for (int r = 0; r < 3; r++) begin
        s[r] <= SUM_W'(h[r]) + SUM_W'(g[r]);
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/lpcp_div.sv @@
`default_nettype none
// Two restoring dividers sharing one divisor, one quotient bit per stage.
module lpcp_div import lpcp_pkg::*; #(
  parameter int QB = 12
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sums_t           sums,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [QB-1:0]        q0,
  output logic [QB-1:0]        q1,
  output logic                 live
);
  localparam int NW = SUM_W - 1;
  localparam int DW = NW + QB;

  logic [QB:0]    v;
  logic [QB:0]    adv;
  logic [DW-1:0]  rem0 [QB+1];
  logic [DW-1:0]  rem1 [QB+1];
  logic [NW-1:0]  dv   [QB+1];
  logic [QB-1:0]  qa   [QB+1];
  logic [QB-1:0]  qb   [QB+1];
  logic           lv   [QB+1];

  logic              pos;
  logic              ok0;
  logic              ok1;
  logic [NW-1:0]     n0;
  logic [NW-1:0]     n1;
  logic [DW-1:0]     dtop;
  logic signed [SUM_W:0] t0;
  logic signed [SUM_W:0] t1;

  always_comb begin
    adv[QB] = !v[QB] || out_ready;
    for (int i = QB - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[QB];
  assign q0        = qa[QB];
  assign q1        = qb[QB];
  assign live      = lv[QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i <= QB; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // Truncation toward zero: a negative numerator above -s2 still gives zero.
  always_comb begin
    pos  = sums.s2 > 0;
    t0   = (SUM_W+1)'(sums.s0) + (SUM_W+1)'(sums.s2);
    t1   = (SUM_W+1)'(sums.s1) + (SUM_W+1)'(sums.s2);
    ok0  = t0 > 0;
    ok1  = t1 > 0;
    n0   = sums.s0[SUM_W-1] ? '0 : sums.s0[NW-1:0];
    n1   = sums.s1[SUM_W-1] ? '0 : sums.s1[NW-1:0];
    dtop = DW'(sums.s2[NW-1:0]) << QB;
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      rem0[0] <= DW'(n0);
      rem1[0] <= DW'(n1);
      dv[0]   <= sums.s2[NW-1:0];
      qa[0]   <= '0;
      qb[0]   <= '0;
      lv[0]   <= pos && ok0 && ok1 && (DW'(n0) < dtop) && (DW'(n1) < dtop);
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int K = QB - j;
    logic [DW-1:0] trial;
    logic          ge0;
    logic          ge1;

    always_comb begin
      trial = DW'(dv[j-1]) << K;
      ge0   = rem0[j-1] >= trial;
      ge1   = rem1[j-1] >= trial;
    end

    always_ff @(posedge clk) begin
      if (adv[j] && v[j-1]) begin
        rem0[j]    <= ge0 ? rem0[j-1] - trial : rem0[j-1];
        rem1[j]    <= ge1 ? rem1[j-1] - trial : rem1[j-1];
        dv[j]      <= dv[j-1];
        lv[j]      <= lv[j-1];
        qa[j]      <= qa[j-1] | (QB'(ge0) << K);
        qb[j]      <= qb[j-1] | (QB'(ge1) << K);
      end
    end
  end
endmodule
`default_nettype wire
